FILE: design/hsid_pkg.sv
// Shared types, constants and helpers for the half-space distance block.
// No dependencies; every other design file imports this package.
package hsid_pkg;

   localparam int MAX_PLANES_DEF = 16;
   localparam int GRID_DIM_MAX   = 1024;
   localparam int MUL_STEPS      = 6;
   localparam int ROOT_STEPS     = 32;
   localparam int DIV_STEPS      = 64;

   localparam logic [2:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z    = 3'd2;
   localparam logic [2:0] CSR_SPACING_X   = 3'd3;
   localparam logic [2:0] CSR_SPACING_Y   = 3'd4;
   localparam logic [2:0] CSR_SPACING_Z   = 3'd5;
   localparam logic [2:0] CSR_PLANE_COUNT = 3'd6;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [30:0] SPACING_RESET = 31'd65536;
   localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] DIST_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic              op;
      logic [3:0]        plane_slot;
      logic signed [31:0] nvec_x;
      logic signed [31:0] nvec_y;
      logic signed [31:0] nvec_z;
      logic signed [31:0] anchor_x;
      logic signed [31:0] anchor_y;
      logic signed [31:0] anchor_z;
      logic [9:0]        grid_i;
      logic [9:0]        grid_j;
      logic [9:0]        grid_k;
   } hsid_req_type;

   typedef struct packed {
      logic signed [31:0] distance;
      logic              degenerate;
   } hsid_rsp_type;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
   } plane_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_POS, ST_SEL, ST_DIFF, ST_MUL, ST_CHK, ST_ROOT, ST_NEXT, ST_DONE
   } hsid_state_type;

   typedef enum logic [2:0] {
      UN_IDLE, UN_ROOT, UN_RND, UN_DIV, UN_FIN
   } hsid_unit_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = DIST_MAX;
      end else if (v < -66'sd2147483648) begin
         r = DIST_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : v;
      return r;
   endfunction

endpackage

FILE: design/hsid_cell.sv
// One plane slot of the rotating plane table.
// Depends on hsid_pkg for plane_type.
module hsid_cell import hsid_pkg::*; (
   input  logic      clock,
   input  logic      load_en,
   input  plane_type load_plane,
   input  logic      shift_en,
   input  plane_type nbr_plane,
   output plane_type plane
);

   plane_type plane_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         plane_ff <= load_plane;
      end else if (shift_en) begin
         plane_ff <= nbr_plane;
      end
   end

   assign plane = plane_ff;

endmodule

FILE: design/hsid_norm_div.sv
// Bit-serial rounded square root of the normal's squared length, then a
// restoring divide of the dot-product magnitude by it. Depends on hsid_pkg.
module hsid_norm_div import hsid_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        sq_in,
   input  logic [63:0]        mag_in,
   input  logic               neg_in,
   output logic               done,
   output logic signed [31:0] dist_out
);

   hsid_unit_state_type state_ff, state_in;

   logic [63:0] qsh_ff;
   logic [32:0] srem_ff;
   logic [31:0] root_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] len_ff;
   logic [63:0] msh_ff;
   logic [31:0] drem_ff;
   logic [63:0] quo_ff;
   logic        neg_ff;

   logic [34:0] rem_sh;
   logic [34:0] trial;
   logic        root_ge;
   logic [32:0] dtry;
   logic        div_ge;

   assign rem_sh  = {srem_ff, qsh_ff[63:62]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign root_ge = rem_sh >= trial;
   assign dtry    = {drem_ff, msh_ff[63]};
   assign div_ge  = dtry >= {1'b0, len_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         UN_IDLE: if (start) state_in = UN_ROOT;
         UN_ROOT: if (cnt_ff == 6'(ROOT_STEPS - 1)) state_in = UN_RND;
         UN_RND:  state_in = UN_DIV;
         UN_DIV:  if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = UN_FIN;
         UN_FIN:  state_in = UN_IDLE;
         default: state_in = UN_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == UN_FIN);
      if (neg_ff) begin
         dist_out = (quo_ff >= 64'h8000_0000) ? DIST_MIN : signed'(32'(-quo_ff[31:0]));
      end else begin
         dist_out = (quo_ff > 64'h7fff_ffff) ? DIST_MAX : signed'(quo_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         UN_IDLE: begin
            if (start) begin
               qsh_ff  <= sq_in;
               msh_ff  <= mag_in;
               neg_ff  <= neg_in;
               srem_ff <= '0;
               root_ff <= '0;
               cnt_ff  <= '0;
            end
         end
         UN_ROOT: begin
            qsh_ff  <= {qsh_ff[61:0], 2'b00};
            srem_ff <= root_ge ? 33'(rem_sh - trial) : rem_sh[32:0];
            root_ff <= {root_ff[30:0], root_ge};
            cnt_ff  <= cnt_ff + 6'd1;
         end
         UN_RND: begin
            len_ff  <= root_ff + 32'(srem_ff > {1'b0, root_ff});
            cnt_ff  <= '0;
            drem_ff <= '0;
         end
         UN_DIV: begin
            drem_ff <= div_ge ? 32'(dtry - {1'b0, len_ff}) : dtry[31:0];
            msh_ff  <= {msh_ff[62:0], 1'b0};
            quo_ff  <= {quo_ff[62:0], div_ge};
            cnt_ff  <= cnt_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: design/half_space_intersection_distance.sv
// Top level: config registers, rotating plane table, per-plane sequencer.
// Depends on hsid_pkg, hsid_cell and hsid_norm_div.
//
// Load beats return nothing. An evaluate beat visits each active plane in
// turn and passes over each unused slot; the per-plane time is set by the
// shared unit's 32-step square root and 64-step divide (skipped for a plane
// with a zero normal), and each plane reaches the head of the table ring by
// one rotation step. The result sits in an output register, and the next beat
// is taken once the sequencer is back to idle.
module half_space_intersection_distance import hsid_pkg::*; #(
   parameter int MAX_PLANES = MAX_PLANES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  hsid_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output hsid_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int CW = $clog2(MAX_PLANES + 1);

   hsid_state_type state_ff, state_in;

   logic signed [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [30:0]        spacing_x_ff, spacing_y_ff, spacing_z_ff;
   logic [4:0]         plane_count_ff;

   logic [9:0]         gi_ff, gj_ff, gk_ff;
   logic signed [31:0] pos_ff [3];
   logic [31:0]        dmag_ff [3];
   logic [31:0]        nmag_ff [3];
   logic               sdiff_ff [3];
   logic [2:0]         mstep_ff;
   logic [63:0]        prod_ff;
   logic [2:0]         tag_ff;
   logic               pvld_ff;
   logic [63:0]        pos_sum_ff, neg_sum_ff, q_ff;
   logic signed [31:0] best_ff;
   logic               degen_ff;
   logic [CW-1:0]      rot_ff;
   logic               rsp_valid_ff;
   hsid_rsp_type       rsp_data_ff;

   plane_type          cell_q [MAX_PLANES];
   plane_type          head;
   plane_type          in_plane;
   logic [CW-1:0]      active;
   logic               shift_en, unit_start, rsp_load;
   logic               unit_done;
   logic signed [31:0] unit_dist;
   logic               sum_neg;
   logic [63:0]        sum_mag;
   logic [1:0]         mc;
   logic [31:0]        opa, opb;
   logic signed [31:0] pos_c [3];
   logic signed [31:0] d_c [3];
   logic [9:0]         aidx [3];
   logic [30:0]        astep [3];
   logic signed [31:0] aorg [3];
   logic signed [31:0] anc [3];
   logic signed [31:0] nrm [3];

   function automatic logic [9:0] clamp_idx(input logic [9:0] g);
      logic [9:0] r;
      r = (32'(g) > GRID_DIM_MAX - 1) ? 10'(GRID_DIM_MAX - 1) : g;
      return r;
   endfunction

   assign in_plane = '{nx: req_data.nvec_x, ny: req_data.nvec_y, nz: req_data.nvec_z,
                       ax: req_data.anchor_x, ay: req_data.anchor_y, az: req_data.anchor_z};

   for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
      hsid_cell u_cell (
         .clock      (clock),
         .load_en    (req_valid && req_ready && req_data.op == OP_LOAD
                      && 32'(req_data.plane_slot) == i),
         .load_plane (in_plane),
         .shift_en   (shift_en),
         .nbr_plane  (cell_q[(i + 1) % MAX_PLANES]),
         .plane      (cell_q[i])
      );
   end

   assign head = cell_q[0];

   always_comb begin
      if (32'(plane_count_ff) > MAX_PLANES) begin
         active = CW'(MAX_PLANES);
      end else begin
         active = CW'(plane_count_ff);
      end
   end

   // position and per-axis difference
   always_comb begin
      aidx[0] = gi_ff; aidx[1] = gj_ff; aidx[2] = gk_ff;
      astep[0] = spacing_x_ff; astep[1] = spacing_y_ff; astep[2] = spacing_z_ff;
      aorg[0] = origin_x_ff; aorg[1] = origin_y_ff; aorg[2] = origin_z_ff;
      anc[0] = head.ax; anc[1] = head.ay; anc[2] = head.az;
      nrm[0] = head.nx; nrm[1] = head.ny; nrm[2] = head.nz;
      for (int c = 0; c < 3; c++) begin
         pos_c[c] = sat32($signed({{34{aorg[c][31]}}, aorg[c]})
                          + $signed({25'b0, 41'(astep[c]) * 41'(aidx[c])}));
         d_c[c] = sat32($signed({{34{pos_ff[c][31]}}, pos_ff[c]})
                        - $signed({{34{anc[c][31]}}, anc[c]}));
      end
   end

   always_comb begin
      if (mstep_ff < 3'd3) begin
         mc = mstep_ff[1:0];
      end else if (mstep_ff < 3'(MUL_STEPS)) begin
         mc = 2'(mstep_ff - 3'd3);
      end else begin
         mc = 2'd0;
      end
      opa = (mstep_ff < 3'd3) ? dmag_ff[mc] : nmag_ff[mc];
      opb = nmag_ff[mc];
   end

   assign sum_neg = neg_sum_ff > pos_sum_ff;
   assign sum_mag = sum_neg ? neg_sum_ff - pos_sum_ff : pos_sum_ff - neg_sum_ff;

   hsid_norm_div u_norm_div (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .sq_in    (q_ff),
      .mag_in   (sum_mag),
      .neg_in   (sum_neg),
      .done     (unit_done),
      .dist_out (unit_dist)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid && req_data.op == OP_EVAL) state_in = ST_POS;
         ST_POS:  state_in = ST_SEL;
         ST_SEL: begin
            if (rot_ff < active) begin
               state_in = ST_DIFF;
            end else if (rot_ff == CW'(MAX_PLANES)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  if (mstep_ff == 3'(MUL_STEPS)) state_in = ST_CHK;
         ST_CHK:  state_in = (q_ff == '0) ? ST_NEXT : ST_ROOT;
         ST_ROOT: if (unit_done) state_in = ST_NEXT;
         ST_NEXT: state_in = ST_SEL;
         ST_DONE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      shift_en   = (state_ff == ST_NEXT);
      unit_start = (state_ff == ST_CHK) && (q_ff != '0);
      rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         spacing_x_ff   <= SPACING_RESET;
         spacing_y_ff   <= SPACING_RESET;
         spacing_z_ff   <= SPACING_RESET;
         plane_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         pvld_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:    origin_x_ff    <= csr_data;
               CSR_ORIGIN_Y:    origin_y_ff    <= csr_data;
               CSR_ORIGIN_Z:    origin_z_ff    <= csr_data;
               CSR_SPACING_X:   spacing_x_ff   <= csr_data[30:0];
               CSR_SPACING_Y:   spacing_y_ff   <= csr_data[30:0];
               CSR_SPACING_Z:   spacing_z_ff   <= csr_data[30:0];
               CSR_PLANE_COUNT: plane_count_ff <= csr_data[4:0];
               default: begin
               end
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         pvld_ff <= (state_ff == ST_MUL) && (mstep_ff < 3'(MUL_STEPS));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_data.op == OP_EVAL) begin
         gi_ff    <= clamp_idx(req_data.grid_i);
         gj_ff    <= clamp_idx(req_data.grid_j);
         gk_ff    <= clamp_idx(req_data.grid_k);
         rot_ff   <= '0;
         best_ff  <= DIST_MIN;
         degen_ff <= 1'b0;
      end
      if (state_ff == ST_POS) begin
         for (int c = 0; c < 3; c++) pos_ff[c] <= pos_c[c];
      end
      if (state_ff == ST_DIFF) begin
         for (int c = 0; c < 3; c++) begin
            dmag_ff[c]  <= mag32(d_c[c]);
            nmag_ff[c]  <= mag32(nrm[c]);
            sdiff_ff[c] <= d_c[c][31] != nrm[c][31];
         end
         mstep_ff   <= '0;
         pos_sum_ff <= '0;
         neg_sum_ff <= '0;
         q_ff       <= '0;
      end else if (pvld_ff) begin
         if (tag_ff < 3'd3) begin
            if (sdiff_ff[tag_ff[1:0]]) begin
               neg_sum_ff <= neg_sum_ff + prod_ff;
            end else begin
               pos_sum_ff <= pos_sum_ff + prod_ff;
            end
         end else begin
            q_ff <= q_ff + prod_ff;
         end
      end
      if (state_ff == ST_MUL) begin
         prod_ff  <= 64'(opa) * 64'(opb);
         tag_ff   <= mstep_ff;
         mstep_ff <= mstep_ff + 3'd1;
      end
      if (state_ff == ST_CHK && q_ff == '0) begin
         degen_ff <= 1'b1;
      end
      if (state_ff == ST_ROOT && unit_done && unit_dist > best_ff) begin
         best_ff <= unit_dist;
      end
      if (shift_en) begin
         rot_ff <= rot_ff + CW'(1);
      end
      if (rsp_load) begin
         rsp_data_ff.distance   <= best_ff;
         rsp_data_ff.degenerate <= degen_ff;
      end
   end

`ifndef SYNTHESIS
   // ring must be back in slot order before the result leaves
   a_ring_restored: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (32'(rot_ff) == MAX_PLANES))
      else $error("plane ring not fully rotated at result");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (q_ff != '0))
      else $error("divide started on zero-length normal");
`endif

endmodule
